/* hw/rtl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

  localparam int unsigned PRIO_W = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FILL_W = 5;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic              mode;
    logic [PRIO_W-1:0] priority_req;
    logic [DATA_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data_out;
    logic [FILL_W-1:0] fill_after;
  } out_word_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t fresh;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/spq_cell.sv */
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       occ,
  input  wire logic       prev_ge,
  input  wire entry_t     prev_entry,
  input  wire entry_t     next_entry,
  output entry_t          entry,
  output logic            ge
);

  entry_t entry_r;
  entry_t entry_nxt;

  assign entry = entry_r;
  assign ge    = occ && (entry_r.prio >= ctrl.fresh.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.enq && !ge) begin
      entry_nxt = prev_ge ? ctrl.fresh : prev_entry;
    end else if (ctrl.deq) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/sorted_priority_queue_top.sv */
`default_nettype none

// A word accepted at a clock edge has its result registered into out_word at that same edge.
// Throughput: one word per cycle while in_stall is low; every cell compares and shifts in the cycle of acceptance.
// in_stall rises only while a finished result waits and out_stall holds it.
// Reset (rst_n low, synchronous): queue empty, no result pending; cell contents unchanged.
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic             out_valid_r;
  out_word_t        out_word_r;
  out_word_t        out_word_nxt;

  logic             accept;
  logic             full;
  logic             empty;
  logic             enq_ok;
  logic             deq_ok;
  cell_ctrl_t       ctrl;

  entry_t           cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_ge;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign full      = (fill_r == CNT_W'(DEPTH));
  assign empty     = (fill_r == '0);
  assign enq_ok    = accept && (in_word.mode == MODE_ENQ) && !full;
  assign deq_ok    = accept && (in_word.mode == MODE_DEQ) && !empty;

  assign ctrl.enq        = enq_ok;
  assign ctrl.deq        = deq_ok;
  assign ctrl.fresh.prio = in_word.priority_req;
  assign ctrl.fresh.data = in_word.data_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occ;
    logic   prev_ge;
    entry_t prev_entry;
    entry_t next_entry;

    assign occ = (CNT_W'(i) < fill_r);

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign prev_entry = ctrl.fresh;
    end else begin : g_body
      assign prev_ge    = cell_ge[i-1];
      assign prev_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = cell_entry[i];
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ),
      .prev_ge    (prev_ge),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (cell_entry[i]),
      .ge         (cell_ge[i])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (enq_ok) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (deq_ok) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_word_nxt.ok         = enq_ok || deq_ok;
    out_word_nxt.data_out   = deq_ok ? cell_entry[0].data : '0;
    out_word_nxt.fill_after = FILL_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

/* tb/sorted_priority_queue_top_tb.sv */
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int IDLE_LIMIT = 2000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  logic [PRIO_W-1:0] q_prio [QDEPTH];
  logic [DATA_W-1:0] q_data [QDEPTH];
  int                q_fill = 0;

  out_word_t      pending_results [$];
  int             errors = 0;
  int             idle_cycles = 0;
  int             burst_left = 0;
  stall_pattern_e stall_pattern = STALL_NONE;
  int             stall_span = 0;
  int             stall_cyc = 0;

  sorted_priority_queue_top #(.DEPTH(QDEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  function automatic out_word_t queue_op_result(input in_word_t w);
    out_word_t r;
    int pos;
    r = '0;
    if (w.mode == MODE_ENQ) begin
      if (q_fill < QDEPTH) begin
        pos = q_fill;
        while (pos > 0 && q_prio[pos-1] < w.priority_req) begin
          q_prio[pos] = q_prio[pos-1];
          q_data[pos] = q_data[pos-1];
          pos--;
        end
        q_prio[pos] = w.priority_req;
        q_data[pos] = w.data_in;
        q_fill++;
        r.ok = 1'b1;
      end
    end else begin
      if (q_fill > 0) begin
        r.data_out = q_data[0];
        for (int k = 1; k < q_fill; k++) begin
          q_prio[k-1] = q_prio[k];
          q_data[k-1] = q_data[k];
        end
        q_fill--;
        r.ok = 1'b1;
      end
    end
    r.fill_after = FILL_W'(q_fill);
    return r;
  endfunction

  function automatic in_word_t make_word(input logic mode, input logic [PRIO_W-1:0] prio,
                                         input logic [DATA_W-1:0] data);
    in_word_t w;
    w.mode = mode;
    w.priority_req = prio;
    w.data_in = data;
    return w;
  endfunction

  // hold the word until accepted; gaps fall between bursts
  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic test_dequeue_empty();
    send_word(make_word(MODE_DEQ, 8'hFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_fill_extremes();
    logic [PRIO_W-1:0] prios [QDEPTH] = '{8'd0, 8'd255, 8'd128, 8'd128, 8'd255, 8'd0, 8'd1,
                                          8'd254, 8'd128, 8'd7, 8'd255, 8'd0, 8'd64, 8'd64,
                                          8'd200, 8'd128};
    logic [DATA_W-1:0] d;
    for (int i = 0; i < QDEPTH; i++) begin
      d = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
      send_word(make_word(MODE_ENQ, prios[i], d));
    end
  endtask

  task automatic test_enqueue_full();
    send_word(make_word(MODE_ENQ, 8'd255, 32'hFFFF_FFFF));
  endtask

  task automatic test_partial_drain();
    repeat (7) send_word(make_word(MODE_DEQ, 8'($urandom), $urandom));
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int seg;
    int enq_pct;
    logic [PRIO_W-1:0] p;
    sent = 0;
    while (sent < n_items) begin
      seg = $urandom_range(20, 80);
      case ($urandom_range(0, 3))
        0: enq_pct = 85;
        1: enq_pct = 15;
        2: enq_pct = 50;
        default: enq_pct = 60;
      endcase
      repeat (seg) begin
        p = ($urandom_range(0, 9) < 4) ? 8'($urandom_range(0, 3) * 85) : 8'($urandom);
        send_word(make_word(($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ,
                            p, $urandom));
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_pattern <= stall_pattern_e'($urandom_range(0, 3));
      stall_span    <= $urandom_range(16, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_pattern)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_cyc % 5) < 2);
    endcase
    stall_cyc <= stall_cyc + 1;
  end

  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_word);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_word.ok !== want.ok) begin
            $display("%0t: ok expected %0b got %0b", $time, want.ok, out_word.ok);
            errors++;
          end
          if (out_word.data_out !== want.data_out) begin
            $display("%0t: data_out expected %h got %h", $time, want.data_out,
                     out_word.data_out);
            errors++;
          end
          if (out_word.fill_after !== want.fill_after) begin
            $display("%0t: fill_after expected %0d got %0d", $time, want.fill_after,
                     out_word.fill_after);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(queue_op_result(in_word));
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sorted_priority_queue_top_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_dequeue_empty();
    test_fill_extremes();
    test_enqueue_full();
    test_partial_drain();
    test_random_traffic(1350);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("sorted_priority_queue_top_tb: PASS");
    end else begin
      $display("sorted_priority_queue_top_tb: FAIL");
    end
    $finish;
  end

endmodule
